/* hdl/keyword_lexer_token_coder_macros.svh */
// Assertion macros for the keyword lexer token coder.
// Included by the top level; no other dependencies.
`ifndef KEYWORD_LEXER_TOKEN_CODER_MACROS_SVH
`define KEYWORD_LEXER_TOKEN_CODER_MACROS_SVH
`define KLTC_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define KLTC_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* hdl/kltc_pkg.sv */
// Shared types and constants for the keyword lexer token coder.
// No dependencies.
`default_nettype none
package kltc_pkg;
  localparam int KW_COUNT = 29;
  localparam logic [6:0] CODE_NUMBER = 7'd30;
  localparam logic [6:0] CODE_ERROR = 7'd76;
  localparam logic [6:0] CODE_NEWLINE = 7'd77;
  localparam logic [6:0] CODE_PCT = 7'd75;
  localparam logic [6:0] CODE_HASH = 7'd54;

  typedef enum logic [13:0] {
    M_IDLE = 14'b00000000000001, M_IDENT = 14'b00000000000010,
    M_NUMBER = 14'b00000000000100, M_LT = 14'b00000000001000,
    M_GT = 14'b00000000010000, M_PLUS = 14'b00000000100000,
    M_MINUS = 14'b00000001000000, M_BSL = 14'b00000010000000,
    M_BANG = 14'b00000100000000, M_EQ = 14'b00001000000000,
    M_COLON = 14'b00010000000000, M_HASH1 = 14'b00100000000000,
    M_HASH2 = 14'b01000000000000, M_PCT = 14'b10000000000000
  } mode_t;

  // Token kind handed from the front to the back.
  typedef enum logic [2:0] {
    K_CODE = 3'd0, K_IDENT = 3'd1, K_NUMBER = 3'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] code;
  } tok_t;

  // One queue entry: up to two tokens from a character.
  typedef struct packed {
    logic       two;
    tok_t       t0;
    tok_t       t1;
    logic [4:0] id_len;
    logic [63:0] id_text;
    logic [28:0] id_cand;
    logic [63:0] num;
    logic       ovf;
  } ent_t;

  function automatic logic [79:0] kw_text(input int k);
    case (k)
      0: kw_text = "main"; 1: kw_text = "if"; 2: kw_text = "else";
      3: kw_text = "then"; 4: kw_text = "while"; 5: kw_text = "do";
      6: kw_text = "public"; 7: kw_text = "private"; 8: kw_text = "protect";
      9: kw_text = "switch"; 10: kw_text = "for"; 11: kw_text = "class";
      12: kw_text = "struct"; 13: kw_text = "typedef"; 14: kw_text = "NULL";
      15: kw_text = "include"; 16: kw_text = "using"; 17: kw_text = "namespace";
      18: kw_text = "case"; 19: kw_text = "break"; 20: kw_text = "endl";
      21: kw_text = "return"; 22: kw_text = "int"; 23: kw_text = "double";
      24: kw_text = "float"; 25: kw_text = "bool"; 26: kw_text = "void";
      27: kw_text = "char"; default: kw_text = "string";
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input int k);
    case (k)
      0, 2, 3, 14, 18, 20, 25, 26, 27: kw_len = 4'd4;
      1, 5: kw_len = 4'd2;
      4, 11, 16, 19, 24: kw_len = 4'd5;
      6, 9, 12, 21, 23, 28: kw_len = 4'd6;
      7, 8, 13, 15: kw_len = 4'd7;
      10, 22: kw_len = 4'd3;
      default: kw_len = 4'd9;
    endcase
  endfunction

  // Character at position p of keyword k (strings are right aligned).
  function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
    logic [79:0] s;
    logic [3:0] l;
    s = kw_text(k);
    l = kw_len(k);
    if (p >= l) kw_char = 8'h00;
    else kw_char = s[8*(l-1-p) +: 8];
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

  // Single-character classification: immediate code, CODE_ERROR when unknown.
  function automatic logic [6:0] single_code(input logic [7:0] c);
    case (c)
      "(": single_code = 7'd49; ")": single_code = 7'd50;
      "{": single_code = 7'd51; "}": single_code = 7'd52;
      ",": single_code = 7'd53; "/": single_code = 7'd55;
      8'h09: single_code = 7'd56; ".": single_code = 7'd57;
      "_": single_code = 7'd58; "\"": single_code = 7'd59;
      "'": single_code = 7'd60; "[": single_code = 7'd61;
      "]": single_code = 7'd62; ";": single_code = 7'd63;
      "*": single_code = 7'd64; "&": single_code = 7'd65;
      8'h0a: single_code = CODE_NEWLINE;
      default: single_code = CODE_ERROR;
    endcase
  endfunction

  function automatic mode_t start_mode(input logic [7:0] c);
    if (is_letter(c)) start_mode = M_IDENT;
    else if (is_digit(c)) start_mode = M_NUMBER;
    else
      case (c)
        "<": start_mode = M_LT; ">": start_mode = M_GT;
        "+": start_mode = M_PLUS; "-": start_mode = M_MINUS;
        "\\": start_mode = M_BSL; "!": start_mode = M_BANG;
        "=": start_mode = M_EQ; ":": start_mode = M_COLON;
        "#": start_mode = M_HASH1; "%": start_mode = M_PCT;
        default: start_mode = M_IDLE;
      endcase
  endfunction
endpackage
`default_nettype wire

/* hdl/keyword_lexer_token_coder.sv */
// Keyword lexer token coder, top level: front, request queue and back.
// Depends on kltc_pkg and keyword_lexer_token_coder_macros.svh.
// Takes one character per cycle while the four-entry queue has room; the front
// resolves each character combinationally and the back issues one result per
// cycle while out_stall is low; two results from one character go out in turn.
`default_nettype none
`include "keyword_lexer_token_coder_macros.svh"
module keyword_lexer_token_coder #(
  parameter int MAX_IDENT_LEN = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  character,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [6:0]       token_code,
  output logic [31:0]      number_value,
  output logic             number_overflow,
  output logic [63:0]      ident_text,
  output logic [4:0]       ident_length,
  output logic             last
);
  import kltc_pkg::*;
  logic push, full, nonempty, pop;
  ent_t wdata, rdata;

  kltc_front #(.MAX_IDENT_LEN(MAX_IDENT_LEN), .NUMBER_BITS(NUMBER_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .character,
    .q_push(push), .q_data(wdata), .q_full(full));
  kltc_queue u_queue (.clk, .rst, .push, .wdata, .full, .nonempty, .pop, .rdata);
  kltc_back u_back (
    .clk, .rst, .q_nonempty(nonempty), .q_data(rdata), .q_pop(pop),
    .out_valid, .out_stall, .token_code, .number_value, .number_overflow,
    .ident_text, .ident_length, .last);

  `KLTC_ASSERT_IMP(a_no_push_full, full, !push)
  `KLTC_ASSERT_IMP(a_pop_nonempty, pop, nonempty)
  `KLTC_ASSERT_NXT(a_pop_gives_last, pop, out_valid && last)
endmodule
`default_nettype wire

/* hdl/kltc_front.sv */
// Front end: per-character state machine, identifier and number tracking.
// Depends on kltc_pkg.
`default_nettype none
module kltc_front #(
  parameter int MAX_IDENT_LEN = 16,
  parameter int NUMBER_BITS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    character,
  output logic               q_push,
  output kltc_pkg::ent_t     q_data,
  input  wire logic          q_full
);
  import kltc_pkg::*;
  localparam int LW = $clog2(MAX_IDENT_LEN + 1);

  mode_t mode, mode_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [28:0] cand, cand_next;
  logic [NUMBER_BITS-1:0] acc, acc_next;
  logic ovf, ovf_next;
  logic [63:0] text, text_next;
  logic acc_en;
  logic [NUMBER_BITS+3:0] prod;
  logic [NUMBER_BITS-1:0] dig;
  ent_t e;
  logic fire;

  assign in_stall = q_full;
  assign fire = in_valid && !q_full;
  assign dig = NUMBER_BITS'(character - "0");
  assign prod = ((NUMBER_BITS+4)'(acc) << 3) + ((NUMBER_BITS+4)'(acc) << 1)
              + (NUMBER_BITS+4)'(dig);

  always_comb begin
    mode_t sm;
    logic [6:0] c0;
    logic emit0, restart;
    logic [LW-1:0] p;
    mode_next = mode; cnt_next = cnt; cand_next = cand;
    acc_next = acc; ovf_next = ovf; text_next = text;
    e = '0;
    e.id_len = 5'(cnt > LW'(31) ? 31 : cnt);
    e.id_text = text; e.id_cand = cand;
    for (int k = 0; k < KW_COUNT; k++)
      if (LW'(kw_len(k)) != cnt) e.id_cand[k] = 1'b0;
    e.num = 64'(acc); e.ovf = ovf;
    emit0 = 1'b0; restart = 1'b0; c0 = CODE_ERROR;
    e.t0.kind = K_CODE;
    acc_en = 1'b0;
    p = cnt;
    case (mode)
      M_IDENT:
        if (is_letter(character) || is_digit(character) || character == "_") begin
          for (int k = 0; k < KW_COUNT; k++)
            if (p >= LW'(kw_len(k)) || kw_char(k, 4'(p)) != character)
              cand_next[k] = 1'b0;
          if (p < LW'(MAX_IDENT_LEN)) begin
            cnt_next = p + 1'b1;
            if (p < LW'(8)) text_next[8*p[2:0] +: 8] = character;
          end
        end else begin
          emit0 = 1'b1; e.t0.kind = K_IDENT; restart = 1'b1;
        end
      M_NUMBER:
        if (is_digit(character)) acc_en = 1'b1;
        else begin
          emit0 = 1'b1; e.t0.kind = K_NUMBER; c0 = CODE_NUMBER; restart = 1'b1;
        end
      M_LT: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "<") c0 = 7'd31; else if (character == "=") c0 = 7'd32;
        else begin c0 = 7'd33; restart = 1'b1; end end
      M_GT: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "=") c0 = 7'd34; else if (character == ">") c0 = 7'd35;
        else begin c0 = 7'd36; restart = 1'b1; end end
      M_PLUS: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "=") c0 = 7'd37; else if (character == "+") c0 = 7'd38;
        else begin c0 = 7'd39; restart = 1'b1; end end
      M_MINUS: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "=") c0 = 7'd40; else if (character == "-") c0 = 7'd41;
        else begin c0 = 7'd42; restart = 1'b1; end end
      M_BSL: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "t") c0 = 7'd43;
        else if (character == "n") c0 = CODE_NEWLINE;
        else if (character == "0") c0 = 7'd78;
        else begin c0 = CODE_ERROR; restart = 1'b1; end end
      M_BANG: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "=") c0 = 7'd44;
        else begin c0 = CODE_ERROR; restart = 1'b1; end end
      M_EQ: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "=") c0 = 7'd45;
        else begin c0 = 7'd46; restart = 1'b1; end end
      M_COLON: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == ":") c0 = 7'd47;
        else begin c0 = 7'd48; restart = 1'b1; end end
      M_HASH1:
        if (character == "#") mode_next = M_HASH2;
        else begin emit0 = 1'b1; c0 = CODE_HASH; restart = 1'b1; end
      M_HASH2: begin emit0 = 1'b1; mode_next = M_IDLE;
        if (character == "#") c0 = 7'd79;
        else begin c0 = CODE_ERROR; restart = 1'b1; end end
      M_PCT: begin emit0 = 1'b1; mode_next = M_IDLE;
        case (character)
          "d": c0 = 7'd66; "o": c0 = 7'd67; "x": c0 = 7'd68;
          "u": c0 = 7'd69; "c": c0 = 7'd70; "s": c0 = 7'd71;
          "f": c0 = 7'd72; "e": c0 = 7'd73; "g": c0 = 7'd74;
          default: begin c0 = CODE_PCT; restart = 1'b1; end
        endcase
      end
      default: restart = 1'b1;
    endcase
    e.t0.code = c0;
    if (acc_en) begin
      if (prod[NUMBER_BITS+3:NUMBER_BITS] != '0) begin
        acc_next = '1; ovf_next = 1'b1;
      end else acc_next = prod[NUMBER_BITS-1:0];
    end
    if (restart) begin
      sm = start_mode(character);
      mode_next = sm;
      case (sm)
        M_IDENT: begin
          cnt_next = LW'(1);
          text_next = {56'd0, character};
          for (int k = 0; k < KW_COUNT; k++) cand_next[k] = kw_char(k, 4'd0) == character;
        end
        M_NUMBER: begin acc_next = dig; ovf_next = 1'b0; end
        M_IDLE:
          if (character != " ") begin
            if (emit0) begin
              e.two = 1'b1; e.t1.kind = K_CODE; e.t1.code = single_code(character);
            end else begin
              emit0 = 1'b1; e.t0.kind = K_CODE; e.t0.code = single_code(character);
            end
          end
        default: ;
      endcase
    end
    q_push = fire && emit0;
    q_data = e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE; cnt <= '0; cand <= '1; acc <= '0; ovf <= 1'b0;
    end else if (fire) begin
      mode <= mode_next; cnt <= cnt_next; cand <= cand_next;
      acc <= acc_next; ovf <= ovf_next;
    end
    if (fire) text <= text_next;
  end
endmodule
`default_nettype wire

/* hdl/kltc_queue.sv */
// Short request queue between front and back.
// Depends on kltc_pkg.
`default_nettype none
module kltc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  kltc_pkg::ent_t      wdata,
  output logic                full,
  output logic                nonempty,
  input  wire logic           pop,
  output kltc_pkg::ent_t      rdata
);
  import kltc_pkg::*;
  ent_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] cnt;

  assign full = cnt == 3'd4;
  assign nonempty = cnt != 3'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + 3'(push) - 3'(pop);
    end
    if (push) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

/* hdl/kltc_back.sv */
// Back end: resolves keyword codes and issues result items one at a time.
// Depends on kltc_pkg.
`default_nettype none
module kltc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_nonempty,
  input  kltc_pkg::ent_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [6:0]         token_code,
  output logic [31:0]        number_value,
  output logic               number_overflow,
  output logic [63:0]        ident_text,
  output logic [4:0]         ident_length,
  output logic               last
);
  import kltc_pkg::*;
  logic sel;
  tok_t t;
  logic [6:0] kw;
  logic load;

  assign t = sel ? q_data.t1 : q_data.t0;
  assign load = q_nonempty && (!out_valid || !out_stall);
  assign q_pop = load && (sel || !q_data.two);

  always_comb begin
    kw = 7'd0;
    for (int k = KW_COUNT - 1; k >= 0; k--)
      if (q_data.id_cand[k]) kw = 7'(k + 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0; sel <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel <= q_data.two && !sel;
      end else if (!out_stall) out_valid <= 1'b0;
    end
    if (load) begin
      token_code <= t.kind == K_IDENT ? kw : t.code;
      number_value <= t.kind == K_NUMBER ? 32'(q_data.num) : 32'd0;
      number_overflow <= t.kind == K_NUMBER && q_data.ovf;
      ident_text <= t.kind == K_IDENT ? q_data.id_text : 64'd0;
      ident_length <= t.kind == K_IDENT ? q_data.id_len : 5'd0;
      last <= sel || !q_data.two;
    end
  end
endmodule
`default_nettype wire
